@@ sv/miller_rabin_prime_search_defines.svh @@
// Assertion macros shared by the checker of the prime search block.
// No dependencies.
`ifndef MILLER_RABIN_PRIME_SEARCH_DEFINES_SVH
`define MILLER_RABIN_PRIME_SEARCH_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define MRPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MRPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/mrps_pkg.sv @@
// Package for the prime search block: widths, witness table, opcodes, register address.
// No dependencies.
package mrps_pkg;
  localparam int DataWidth = 64;
  localparam int NumWitnesses = 26;
  localparam int RoundsWidth = 5;
  localparam int CntWidth = $clog2(DataWidth + 1);

  localparam logic [0:0] OpTest = 1'b0;
  localparam logic [0:0] OpSearch = 1'b1;

  localparam logic [2:0] AddrRounds = 3'd0;

  typedef logic [DataWidth-1:0] word_t;

  typedef struct packed {
    logic start;
    word_t a;
    word_t b;
    word_t m;
  } mul_req_t;

  typedef struct packed {
    logic done;
    word_t prod;
  } mul_rsp_t;

  function automatic word_t witness(input logic [RoundsWidth-1:0] i);
    logic [20:0] w;
    case (i)
      5'd0: w = 21'd2;
      5'd1: w = 21'd3;
      5'd2: w = 21'd5;
      5'd3: w = 21'd7;
      5'd4: w = 21'd11;
      5'd5: w = 21'd13;
      5'd6: w = 21'd17;
      5'd7: w = 21'd19;
      5'd8: w = 21'd23;
      5'd9: w = 21'd29;
      5'd10: w = 21'd31;
      5'd11: w = 21'd37;
      5'd12: w = 21'd41;
      5'd13: w = 21'd43;
      5'd14: w = 21'd47;
      5'd15: w = 21'd53;
      5'd16: w = 21'd59;
      5'd17: w = 21'd61;
      5'd18: w = 21'd67;
      5'd19: w = 21'd71;
      5'd20: w = 21'd73;
      5'd21: w = 21'd79;
      5'd22: w = 21'd83;
      5'd23: w = 21'd89;
      5'd24: w = 21'd97;
      5'd25: w = 21'd1662803;
      default: w = 21'd2;
    endcase
    return word_t'(w);
  endfunction
endpackage

@@ sv/miller_rabin_prime_search.sv @@
// Top level of the Miller-Rabin prime test and downward prime search.
// Depends on mrps_pkg, mrps_ctrl and mrps_mulmod.
//
// Input stream s_axis: tdata bits 0..63 are number, tuser bit 0 is opcode
// (0 tests number, 1 searches downward for a prime). Result stream m_axis:
// tdata bits 0..63 are value, tuser bit 0 is is_prime. One result per input.
// The block takes one item at a time; s_axis_tready is low from the transfer
// until the result has left the output register. Every modular product runs
// in the shared multiplier, which moves one multiplier bit per cycle. A test
// runs up to one base per round; a base costs one short reduction product, one
// or two products per bit of d and up to one product per further factor of two
// in p - 1, so the shared multiplier sets the rate.
// A search repeats the test for every odd candidate down to the prime found.
// The output register holds the result while m_axis_tready is low, and no
// new item is taken until the result transfer has completed.
// Synchronous reset clears the handshakes and sets rounds to 26.
// APB register 0 at address 0 holds rounds (5 bits).
module miller_rabin_prime_search import mrps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // number
  input  logic [0:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // value
  output logic [0:0]  m_axis_tuser,   // is_prime
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [RoundsWidth-1:0] rounds;
  logic busy, done, res_prime, start;
  word_t res_value;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrRounds) ? {27'd0, rounds} : 32'd0;
  assign s_axis_tready = !busy && !done && !m_axis_tvalid;
  assign start = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds <= RoundsWidth'(NumWitnesses);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == AddrRounds) rounds <= pwdata[RoundsWidth-1:0];
      if (done) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= res_value;
        m_axis_tuser <= res_prime;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  mrps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .rounds(rounds), .start(start), .op(s_axis_tuser[0]),
    .number(s_axis_tdata), .busy(busy), .done(done), .res_prime(res_prime),
    .res_value(res_value), .mreq(mreq), .mrsp(mrsp)
  );

  mrps_mulmod u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
endmodule

@@ sv/mrps_mulmod.sv @@
// Shared shift-add modular multiplier, one bit of the multiplier per cycle.
// Depends on mrps_pkg. Operands must already be reduced below the modulus.
module mrps_mulmod import mrps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);
  logic busy;
  word_t a, b, m, acc;
  logic [DataWidth:0] s_acc, s_dbl;

  always_comb begin
    s_acc = {1'b0, acc} + {1'b0, a};
    s_dbl = {1'b0, a} + {1'b0, a};
    if (s_acc >= {1'b0, m}) s_acc = s_acc - {1'b0, m};
    if (s_dbl >= {1'b0, m}) s_dbl = s_dbl - {1'b0, m};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        a <= req.a;
        b <= req.b;
        m <= req.m;
        acc <= '0;
      end else if (busy) begin
        if (b == '0) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.prod <= acc;
        end else begin
          if (b[0]) acc <= s_acc[DataWidth-1:0];
          a <= s_dbl[DataWidth-1:0];
          b <= b >> 1;
        end
      end
    end
  end
endmodule

@@ sv/mrps_ctrl.sv @@
// Sequencer for Miller-Rabin tests and the downward prime search.
// Depends on mrps_pkg and drives one shared mrps_mulmod.
module mrps_ctrl import mrps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [RoundsWidth-1:0] rounds,
  input  logic                   start,
  input  logic                   op,
  input  word_t                  number,
  output logic                   busy,
  output logic                   done,
  output logic                   res_prime,
  output word_t                  res_value,
  output mul_req_t               mreq,
  input  mul_rsp_t               mrsp
);
  localparam logic [3:0] SIdle = 4'd0, SCand = 4'd1, SSplit = 4'd2, SBase = 4'd3,
    SRed = 4'd4, SPow = 4'd5, SPowW = 4'd6, SChk = 4'd7, SSq = 4'd8, SSqW = 4'd9,
    SVerd = 4'd10, SFin = 4'd11, SBaseW = 4'd12;

  logic [3:0] state;
  logic opr, pass;
  word_t p, pm1, d, e, base, x;
  logic [CntWidth-1:0] twos, k;
  logic [RoundsWidth-1:0] idx, nr;
  logic pw_sq;

  assign busy = (state != SIdle);
  assign nr = (rounds == '0) ? RoundsWidth'(1) :
              (rounds > RoundsWidth'(NumWitnesses)) ? RoundsWidth'(NumWitnesses) : rounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      done <= 1'b0;
      mreq.start <= 1'b0;
    end else begin
      done <= 1'b0;
      mreq.start <= 1'b0;
      case (state)
        SIdle: begin
          if (start) begin
            opr <= op;
            if (op == OpSearch) begin
              if (number < word_t'(2)) begin
                res_prime <= 1'b0;
                res_value <= '0;
                state <= SFin;
              end else begin
                p <= number[0] ? number : number - word_t'(1);
                state <= SCand;
              end
            end else begin
              p <= number;
              res_value <= number;
              state <= SCand;
            end
          end
        end
        SCand: begin
          if (p < word_t'(2) || (p != word_t'(2) && !p[0])) begin
            pass <= 1'b0;
            state <= SVerd;
          end else if (p == word_t'(2)) begin
            pass <= 1'b1;
            state <= SVerd;
          end else begin
            pm1 <= p - word_t'(1);
            d <= (p - word_t'(1)) >> 1;
            twos <= CntWidth'(1);
            idx <= '0;
            pass <= 1'b1;
            state <= SSplit;
          end
        end
        SSplit: begin
          if (!d[0]) begin
            d <= d >> 1;
            twos <= twos + CntWidth'(1);
          end else begin
            state <= SBase;
          end
        end
        SBase: begin
          if (idx == nr) begin
            state <= SVerd;
          end else begin
            // The witness is reduced modulo p as the product 1 * witness.
            mreq.start <= 1'b1;
            mreq.a <= word_t'(1);
            mreq.b <= witness(idx);
            mreq.m <= p;
            state <= SRed;
          end
        end
        SRed: begin
          if (mrsp.done) begin
            if (mrsp.prod == '0) begin
              idx <= idx + RoundsWidth'(1);
              state <= SBase;
            end else begin
              base <= mrsp.prod;
              e <= d;
              x <= word_t'(1);
              state <= SPow;
            end
          end
        end
        SPow: begin
          if (e == '0) begin
            k <= CntWidth'(1);
            state <= SChk;
          end else begin
            mreq.start <= 1'b1;
            mreq.m <= p;
            pw_sq <= !e[0];
            mreq.a <= e[0] ? x : base;
            mreq.b <= e[0] ? base : base;
            state <= SPowW;
          end
        end
        SPowW: begin
          if (mrsp.done) begin
            if (!pw_sq) begin
              x <= mrsp.prod;
              pw_sq <= 1'b1;
              mreq.start <= 1'b1;
              mreq.a <= base;
              mreq.b <= base;
            end else begin
              base <= mrsp.prod;
              e <= e >> 1;
              state <= SPow;
            end
          end
        end
        SChk: begin
          if (x == word_t'(1) || x == pm1) begin
            idx <= idx + RoundsWidth'(1);
            state <= SBase;
          end else begin
            state <= SSq;
          end
        end
        SSq: begin
          if (k >= twos) begin
            pass <= 1'b0;
            state <= SVerd;
          end else begin
            mreq.start <= 1'b1;
            mreq.a <= x;
            mreq.b <= x;
            mreq.m <= p;
            state <= SSqW;
          end
        end
        SSqW: begin
          if (mrsp.done) begin
            x <= mrsp.prod;
            k <= k + CntWidth'(1);
            state <= SBaseW;
          end
        end
        SBaseW: begin
          if (x == pm1) begin
            idx <= idx + RoundsWidth'(1);
            state <= SBase;
          end else begin
            state <= SSq;
          end
        end
        SVerd: begin
          if (opr == OpTest) begin
            res_prime <= pass;
            state <= SFin;
          end else if (pass || p <= word_t'(2)) begin
            res_prime <= (p > word_t'(1));
            res_value <= (p > word_t'(1)) ? p : '0;
            state <= SFin;
          end else begin
            p <= p - word_t'(2);
            state <= SCand;
          end
        end
        SFin: begin
          done <= 1'b1;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule

@@ sv/mrps_checker.sv @@
// Port-level checker for the prime search block, bound to the top level.
// Depends on miller_rabin_prime_search_defines.svh.
`include "miller_rabin_prime_search_defines.svh"
module mrps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);
  `MRPS_ASSERT_NEXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `MRPS_ASSERT_IMPL(a_no_take_while_out, clk, rst, m_axis_tvalid, !s_axis_tready)
  `MRPS_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `MRPS_ASSERT_IMPL(a_zero_not_prime, clk, rst, m_axis_tvalid && m_axis_tdata == 64'd0, m_axis_tuser == 1'b0)
endmodule

bind miller_rabin_prime_search mrps_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

@@ tb/sv/miller_rabin_prime_search_tb.sv @@
// Testbench for miller_rabin_prime_search: drives tests and downward searches over
// the input stream, predicts each result and checks the result stream field by field.
// Depends on mrps_pkg and the RTL of the block.
module miller_rabin_prime_search_tb;
  import mrps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic  is_prime;
    word_t value;
  } prime_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // number
  logic [0:0]  s_axis_tuser;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // value
  logic [0:0]  m_axis_tuser;   // is_prime
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prime_result_t pending_results[$];
  int            mismatch_count = 0;
  int            sink_stall_left = 0;
  bit            quiet_phase = 0;
  logic [4:0]    rounds_reg = 5'd26;
  word_t         witness_list[26] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17,
      64'd19, 64'd23, 64'd29, 64'd31, 64'd37, 64'd41, 64'd43, 64'd47, 64'd53, 64'd59,
      64'd61, 64'd67, 64'd71, 64'd73, 64'd79, 64'd83, 64'd89, 64'd97, 64'd1662803};

  miller_rabin_prime_search u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    word_t gap;
    gap = m - y;
    if (x >= gap) return x - gap;
    return x + y;
  endfunction

  function automatic word_t mul_mod(word_t a, word_t b, word_t m);
    word_t acc;
    acc = '0;
    if (m == 0) return '0;
    a = a % m;
    b = b % m;
    while (b != 0) begin
      if (b[0]) acc = add_mod(acc, a, m);
      a = add_mod(a, a, m);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic word_t pow_mod(word_t b, word_t e, word_t m);
    word_t acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit passes_witnesses(word_t p);
    word_t d, pm1, a, x;
    int    twos, n;
    bit    ok;
    if (p < 2) return 0;
    if (p == 2) return 1;
    if (!p[0]) return 0;
    pm1 = p - 1;
    d = pm1;
    twos = 0;
    while (!d[0]) begin
      d = d >> 1;
      twos++;
    end
    n = (rounds_reg < 1) ? 1 : ((rounds_reg > 26) ? 26 : rounds_reg);
    for (int i = 0; i < n; i++) begin
      a = witness_list[i] % p;
      if (a == 0) continue;
      x = pow_mod(a, d, p);
      if (x == 1 || x == pm1) continue;
      ok = 0;
      for (int k = 1; k < twos; k++) begin
        x = mul_mod(x, x, p);
        if (x == pm1) begin
          ok = 1;
          break;
        end
      end
      if (!ok) return 0;
    end
    return 1;
  endfunction

  function automatic word_t prime_below(word_t n);
    if (n < 2) return '0;
    if (!n[0]) n = n - 1;
    while (!passes_witnesses(n) && n > 2) n = n - 2;
    return (n > 1) ? n : '0;
  endfunction

  function automatic prime_result_t predict_result(logic [0:0] op, word_t num);
    prime_result_t r;
    if (op == OpTest) begin
      r.is_prime = passes_witnesses(num);
      r.value = num;
    end else begin
      r.value = prime_below(num);
      r.is_prime = (r.value != 0);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    prime_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, value", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[0] !== want.is_prime)
          report_mismatch("is_prime", word_t'(m_axis_tuser), word_t'(want.is_prime));
        if (m_axis_tdata !== want.value)
          report_mismatch("value", m_axis_tdata, want.value);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || quiet_phase) begin
      m_axis_tready <= 1'b1;
    end else if (sink_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      sink_stall_left = $urandom_range(0, 11);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_rounds(logic [4:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrRounds;
    pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rounds_reg = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(logic [0:0] op, word_t num);
    prime_result_t want;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    want = predict_result(op, num);
    s_axis_tdata <= num;
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic test_reset_rounds_directed();
    send_item(OpTest, 64'd0);
    send_item(OpTest, 64'd1);
    send_item(OpTest, 64'd2);
    send_item(OpTest, 64'd3);
    send_item(OpTest, 64'd4);
    send_item(OpTest, 64'd97);
    send_item(OpTest, 64'd561);
    send_item(OpTest, 64'd1662803);
    send_item(OpTest, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OpSearch, 64'd0);
    send_item(OpSearch, 64'd1);
    send_item(OpSearch, 64'd2);
    send_item(OpSearch, 64'd3);
    send_item(OpSearch, 64'd4);
    send_item(OpSearch, 64'd100);
    drain_results();
  endtask

  task automatic test_rounds_extremes();
    write_rounds(5'd0);
    send_item(OpTest, 64'd2047);
    send_item(OpSearch, 64'hFFFF_FFFF_FFFF_FFFF);
    drain_results();
    write_rounds(5'd31);
    send_item(OpTest, 64'd2047);
    send_item(OpSearch, 64'd1000);
    drain_results();
    write_rounds(5'd4);
    send_item(OpTest, 64'd3215031751);
    send_item(OpTest, 64'h8000_0000_0000_0000);
    drain_results();
  endtask

  task automatic test_random_items();
    word_t num;
    for (int phase = 0; phase < 4; phase++) begin
      write_rounds(5'($urandom_range(1, 4)));
      if (phase == 3) quiet_phase = 1;
      for (int i = 0; i < 25; i++) begin
        case ($urandom_range(0, 9))
          0: begin
            num = {$urandom, $urandom};
            send_item(OpTest, num);
          end
          1: send_item(1'($urandom_range(0, 1)), word_t'($urandom_range(0, 65535)));
          default: send_item(1'($urandom_range(0, 1)), word_t'($urandom_range(0, 4095)));
        endcase
      end
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_rounds_directed();
    test_rounds_extremes();
    test_random_items();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("miller_rabin_prime_search verification clean");
    end else begin
      $display("miller_rabin_prime_search verification failed");
    end
    $finish;
  end

  initial begin
    #(64'd40_000_000 * 12);
    $display("miller_rabin_prime_search verification failed");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/mrps_pkg.sv
sv/mrps_mulmod.sv
sv/mrps_ctrl.sv
sv/miller_rabin_prime_search.sv
sv/mrps_checker.sv
tb/sv/miller_rabin_prime_search_tb.sv
